>>> rtl/lifn_pkg.sv
// lifn_pkg: shared types and constants for the leaky integrate-and-fire neuron bank
// no dependencies; used by the top level
package lifn_pkg;

    // field widths
    localparam int VOLT_W  = 24;   // signed Q8.16 voltage
    localparam int BOOST_W = 23;   // unsigned Q7.16 boost
    localparam int COEF_W  = 16;   // unsigned Q0.16 coefficient
    localparam int REFR_W  = 16;   // refractory sample count
    localparam int CHAN_W  = 6;    // channel number field
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_THRESHOLD      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_THRESHOLD_BOOST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LEVEL          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEFF        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_DECAY         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_SAMPLES  = 3'd5;

    // per-channel state word as stored in the state memory
    typedef struct packed {
        logic signed [VOLT_W-1:0] membrane;
        logic [BOOST_W-1:0]       boost_now;
        logic [REFR_W-1:0]        refractory_left;
        logic                     in_refractory;
    } chan_state_t;

    localparam int STATE_W = $bits(chan_state_t);

    // item in the second pipeline stage, after the multipliers
    typedef struct packed {
        logic                     valid;
        logic                     in_bank;
        logic [CHAN_W-1:0]        channel;
        logic signed [VOLT_W-1:0] membrane;
        logic signed [VOLT_W:0]   delta;
        logic [BOOST_W-1:0]       boost_dec;
        logic [REFR_W-1:0]        refractory_left;
        logic                     in_refractory;
    } upd_stage_t;

endpackage

>>> rtl/lifn_ram.sv
// lifn_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
module lifn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/leaky_integrate_fire_neuron_bank.sv
// leaky_integrate_fire_neuron_bank: top level of the neuron bank
// depends on lifn_pkg and lifn_ram
//
// Bank of CHANNELS leaky integrate-and-fire neurons whose state lives in one
// state memory. Each input item is a Q8.16 sample and a channel number; each
// produces exactly one output item with the spike flag and the channel. The
// block takes one item per cycle unless the output stalls; an accepted item
// passes the first-stage registers, b_reg and the output register. The
// read-modify-write of a channel spans two stages (multiply, then add and
// threshold compare), so an item for the channel in the multiply stage is
// held off until that item moves on; items that alternate over channels run
// at full rate. After reset a clearing pass writes every memory entry and no
// item is taken meanwhile. The user must write configuration registers
// through cfg_we/cfg_index/cfg_data only while the bank is idle; the block
// does not enforce this. They take effect with the next item.
module leaky_integrate_fire_neuron_bank #(
    parameter int CHANNELS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [23:0] sample_value, [29:24] channel_index
    // output items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] spike, [6:1] spike_channel
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int VW = lifn_pkg::VOLT_W;
    localparam int BW = lifn_pkg::BOOST_W;
    localparam int RW = lifn_pkg::REFR_W;
    localparam int CW = lifn_pkg::CHAN_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(CHANNELS - 1);

    // configuration registers
    logic signed [VW-1:0]             fire_threshold_reg;
    logic [BW-1:0]                    max_boost_reg;
    logic signed [VW-1:0]             rest_level_reg;
    logic [lifn_pkg::COEF_W-1:0]      filter_coeff_reg;
    logic [lifn_pkg::COEF_W-1:0]      boost_decay_reg;
    logic [RW-1:0]                    refr_samples_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fire_threshold_reg <= '0;
            max_boost_reg      <= '0;
            rest_level_reg     <= '0;
            filter_coeff_reg   <= '0;
            boost_decay_reg    <= '0;
            refr_samples_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lifn_pkg::CFG_FIRE_THRESHOLD:      fire_threshold_reg <= cfg_data;
                lifn_pkg::CFG_MAX_THRESHOLD_BOOST: max_boost_reg      <= cfg_data[BW-1:0];
                lifn_pkg::CFG_REST_LEVEL:          rest_level_reg     <= cfg_data;
                lifn_pkg::CFG_FILTER_COEFF:        filter_coeff_reg   <= cfg_data[15:0];
                lifn_pkg::CFG_BOOST_DECAY:         boost_decay_reg    <= cfg_data[15:0];
                lifn_pkg::CFG_REFRACTORY_SAMPLES:  refr_samples_reg   <= cfg_data[15:0];
                default:                           ;
            endcase
        end
    end

    // input fields
    logic signed [VW-1:0] in_sample;
    logic [CW-1:0]        in_channel;
    assign in_sample  = s_axis_tdata[23:0];
    assign in_channel = s_axis_tdata[29:24];

    // pipeline control
    logic                 clearing_reg;
    logic [AW-1:0]        clr_addr_reg;
    logic                 out_valid_reg;
    logic                 out_spike_reg;
    logic [CW-1:0]        out_channel_reg;
    logic                 a_valid_reg;
    logic signed [VW-1:0] a_sample_reg;
    logic [CW-1:0]        a_channel_reg;
    lifn_pkg::upd_stage_t b_reg;
    logic                 advance;
    logic                 in_accept;

    assign advance = !out_valid_reg || m_axis_tready;
    // hold off an item for the channel that is still in the multiply stage
    assign s_axis_tready = advance && !clearing_reg &&
                           !(a_valid_reg && (a_channel_reg == in_channel));
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // state memory
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    lifn_pkg::chan_state_t  ram_wdata;
    lifn_pkg::chan_state_t  ram_rdata;
    lifn_pkg::chan_state_t  upd_state;
    logic                   upd_we;

    assign ram_we    = clearing_reg || upd_we;
    assign ram_waddr = clearing_reg ? clr_addr_reg : AW'(b_reg.channel);
    assign ram_wdata = clearing_reg ? lifn_pkg::chan_state_t'('0) : upd_state;

    lifn_ram #(
        .WIDTH (lifn_pkg::STATE_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (AW'(in_channel)),
        .rdata (ram_rdata)
    );

    // copy of the last write, forwarded over a same-address read
    logic                  wb_valid_reg;
    logic [CW-1:0]         wb_channel_reg;
    lifn_pkg::chan_state_t wb_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else if (upd_we)
        begin
            wb_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_we)
        begin
            wb_channel_reg <= b_reg.channel;
            wb_data_reg    <= upd_state;
        end
    end

    // first stage: item registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_sample_reg  <= in_sample;
            a_channel_reg <= in_channel;
        end
    end

    // first stage: state select and the two multiplies
    lifn_pkg::chan_state_t   a_state;
    logic signed [VW:0]      a_diff;
    logic signed [VW+17:0]   a_mprod;
    logic [BW+15:0]          a_bprod;
    logic                    a_in_bank;
    lifn_pkg::upd_stage_t    b_next;

    assign a_state   = (wb_valid_reg && (wb_channel_reg == a_channel_reg)) ?
                       wb_data_reg : ram_rdata;
    assign a_diff    = (VW+1)'(a_sample_reg) - (VW+1)'(a_state.membrane);
    assign a_mprod   = a_diff * $signed({1'b0, filter_coeff_reg});
    assign a_bprod   = a_state.boost_now * boost_decay_reg;
    assign a_in_bank = (32'(a_channel_reg) < 32'(CHANNELS));

    always_comb
    begin
        b_next.valid           = a_valid_reg;
        b_next.in_bank         = a_in_bank;
        b_next.channel         = a_channel_reg;
        b_next.membrane        = a_state.membrane;
        // floor of the Q16 product is the arithmetic shift
        b_next.delta           = a_mprod[VW+16:16];
        b_next.boost_dec       = a_bprod[BW+15:16];
        b_next.refractory_left = a_state.refractory_left;
        b_next.in_refractory   = a_state.in_refractory;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else if (advance)
        begin
            b_reg <= b_next;
        end
    end

    // second stage: integrate, threshold test and refractory update
    logic signed [VW+1:0] b_mem_sum;
    logic signed [VW+1:0] b_thr_sum;
    logic                 b_fire;
    logic                 b_expire;
    logic                 b_spike;

    assign b_mem_sum = (VW+2)'(b_reg.membrane) + (VW+2)'(b_reg.delta);
    assign b_thr_sum = (VW+2)'(fire_threshold_reg) + (VW+2)'({1'b0, b_reg.boost_dec});
    assign b_fire    = !b_reg.in_refractory && (b_mem_sum >= b_thr_sum);
    assign b_expire  = (b_reg.refractory_left == RW'(0)) ||
                       (b_reg.refractory_left == RW'(1));
    assign b_spike   = b_reg.in_bank && b_fire;
    assign upd_we    = advance && b_reg.valid && b_reg.in_bank;

    always_comb
    begin
        upd_state.membrane        = b_mem_sum[VW-1:0];
        upd_state.boost_now       = b_reg.boost_dec;
        upd_state.refractory_left = b_reg.refractory_left;
        upd_state.in_refractory   = b_reg.in_refractory;
        if (!b_reg.in_refractory)
        begin
            if (b_fire)
            begin
                upd_state.membrane        = rest_level_reg;
                upd_state.refractory_left = refr_samples_reg;
                upd_state.in_refractory   = 1'b1;
            end
        end
        else
        begin
            // count down, saturating at zero
            if (b_reg.refractory_left != RW'(0))
            begin
                upd_state.refractory_left = b_reg.refractory_left - 1'b1;
            end
            if (b_expire)
            begin
                upd_state.boost_now     = max_boost_reg;
                upd_state.in_refractory = 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= b_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && b_reg.valid)
        begin
            out_spike_reg   <= b_spike;
            out_channel_reg <= b_reg.channel;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_channel_reg, out_spike_reg};

`ifndef SYNTH
    // the interlock keeps one channel out of both update stages at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && b_reg.valid && b_reg.in_bank) |-> (a_channel_reg != b_reg.channel))
        else $error("same channel in both update stages");

    // no item enters while the clearing pass runs
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_axis_tready)
        else $error("item accepted during clearing pass");

    // the clearing pass never overlaps a state update
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !upd_we)
        else $error("state update during clearing pass");

    // a spike comes only from a channel inside the bank
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (32'(m_axis_tdata[6:1]) < 32'(CHANNELS)))
        else $error("spike reported for a channel outside the bank");
`endif

endmodule

>>> tb/leaky_integrate_fire_neuron_bank_test.sv
// leaky_integrate_fire_neuron_bank_test: self-checking testbench for the neuron bank
// depends on lifn_pkg and the leaky_integrate_fire_neuron_bank rtl
// directed table then random phases, each result checked against a behavioral model or a typed-in spike
`timescale 1ns / 1ps

module leaky_integrate_fire_neuron_bank_test;

    localparam int BANK_SIZE  = 64;
    localparam int PREDICT    = -1;     // row result taken from the model
    localparam int LONG_HOLD  = 300;    // receiver hold-off in cycles
    localparam int PHASES     = 7;
    localparam int PHASE_ITEMS = 100;
    localparam int SETTLE_CYCLES = 8;
    localparam int CH_W       = lifn_pkg::CHAN_W;

    typedef enum logic { ROW_SAMPLE, ROW_CONFIG } row_kind_t;

    typedef struct {
        row_kind_t                       kind;
        logic [lifn_pkg::CFG_IDX_W-1:0]  reg_index;
        logic [23:0]                     value;     // register data or sample
        logic [CH_W-1:0]                 channel;
        int                              pinned;    // typed-in spike, or PREDICT
    } stim_row_t;

    typedef struct {
        logic            spike;
        logic [CH_W-1:0] channel;
    } spike_result_t;

    // dut ports
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [23:0] sample_value, [29:24] channel_index
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [0] spike, [6:1] spike_channel

    // model copy of the registers
    logic signed [lifn_pkg::VOLT_W-1:0] thr_reg = '0;
    logic [lifn_pkg::BOOST_W-1:0]       boost_max_reg = '0;
    logic signed [lifn_pkg::VOLT_W-1:0] rest_reg = '0;
    logic [lifn_pkg::COEF_W-1:0]        coeff_reg = '0;
    logic [lifn_pkg::COEF_W-1:0]        decay_reg = '0;
    logic [lifn_pkg::REFR_W-1:0]        refr_len_reg = '0;

    // model copy of the per-channel state
    logic signed [lifn_pkg::VOLT_W-1:0] membrane_v [BANK_SIZE];
    logic [23:0]                        boost_v [BANK_SIZE];
    logic [lifn_pkg::REFR_W-1:0]        refr_left_v [BANK_SIZE];
    bit                                 refr_on_v [BANK_SIZE];

    spike_result_t spikes_due [$];
    int            pinned_spike = PREDICT;
    int            mismatches = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_requests = 0;

    // directed stimulus, reset configuration first
    stim_row_t directed_rows [29] = '{
        // all registers zero: fire, refractory ends on next item, fire again
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h7FFFFF, 6'd0, 1},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h800000, 6'd0, 0},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h000000, 6'd0, 1},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h123456, 6'd63, 1},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'hFFFFFF, 6'd63, 0},
        // strong filter, full boost, two-sample refractory, lowest rest
        '{ROW_CONFIG, lifn_pkg::CFG_FIRE_THRESHOLD,      24'h100000, 6'd0, PREDICT},
        '{ROW_CONFIG, lifn_pkg::CFG_MAX_THRESHOLD_BOOST, 24'h7FFFFF, 6'd0, PREDICT},
        '{ROW_CONFIG, lifn_pkg::CFG_REST_LEVEL,          24'h800000, 6'd0, PREDICT},
        '{ROW_CONFIG, lifn_pkg::CFG_FILTER_COEFF,        24'h00FFFF, 6'd0, PREDICT},
        '{ROW_CONFIG, lifn_pkg::CFG_BOOST_DECAY,         24'h008000, 6'd0, PREDICT},
        '{ROW_CONFIG, lifn_pkg::CFG_REFRACTORY_SAMPLES,  24'h000002, 6'd0, PREDICT},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h7FFFFF, 6'd1, PREDICT},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h000000, 6'd1, PREDICT},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h000000, 6'd1, PREDICT},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h7FFFFF, 6'd1, PREDICT},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h7FFFFF, 6'd1, PREDICT},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h800000, 6'd2, PREDICT},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h7FFFFF, 6'd2, PREDICT},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h7FFFFF, 6'd1, PREDICT},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h7FFFFF, 6'd2, PREDICT},
        // lowest threshold, frozen membrane, boost decays straight to zero
        '{ROW_CONFIG, lifn_pkg::CFG_FIRE_THRESHOLD,      24'h800000, 6'd0, PREDICT},
        '{ROW_CONFIG, lifn_pkg::CFG_MAX_THRESHOLD_BOOST, 24'h7FFFFF, 6'd0, PREDICT},
        '{ROW_CONFIG, lifn_pkg::CFG_REST_LEVEL,          24'h7FFFFF, 6'd0, PREDICT},
        '{ROW_CONFIG, lifn_pkg::CFG_FILTER_COEFF,        24'h000000, 6'd0, PREDICT},
        '{ROW_CONFIG, lifn_pkg::CFG_BOOST_DECAY,         24'h000000, 6'd0, PREDICT},
        '{ROW_CONFIG, lifn_pkg::CFG_REFRACTORY_SAMPLES,  24'h000000, 6'd0, PREDICT},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h7FFFFF, 6'd3, 1},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h000000, 6'd3, 0},
        '{ROW_SAMPLE, lifn_pkg::CFG_FIRE_THRESHOLD, 24'h800000, 6'd3, PREDICT}
    };

    leaky_integrate_fire_neuron_bank u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // register write as seen by the bank
    function automatic void apply_register(input logic [2:0] idx, input logic [23:0] value);
        case (idx)
            lifn_pkg::CFG_FIRE_THRESHOLD:      thr_reg = value;
            lifn_pkg::CFG_MAX_THRESHOLD_BOOST: boost_max_reg = value[lifn_pkg::BOOST_W-1:0];
            lifn_pkg::CFG_REST_LEVEL:          rest_reg = value;
            lifn_pkg::CFG_FILTER_COEFF:        coeff_reg = value[lifn_pkg::COEF_W-1:0];
            lifn_pkg::CFG_BOOST_DECAY:         decay_reg = value[lifn_pkg::COEF_W-1:0];
            lifn_pkg::CFG_REFRACTORY_SAMPLES:  refr_len_reg = value[lifn_pkg::REFR_W-1:0];
            default: ;
        endcase
    endfunction

    // one channel update; returns the spike flag
    function automatic bit integrate_channel(input logic signed [lifn_pkg::VOLT_W-1:0] x,
                                             input int ch);
        longint boost_l;
        longint y;
        longint diff;
        bit     fired;
        bit     expire;
        fired = 1'b0;
        if (ch >= BANK_SIZE)
            return 1'b0;
        // geometric boost decay, truncation drops tiny values to zero
        if (boost_v[ch] != 0)
        begin
            boost_l = (longint'(boost_v[ch]) * longint'(decay_reg)) >>> 16;
            boost_v[ch] = boost_l[23:0];
        end
        // first-order lowpass toward the sample, floor rounding
        y = longint'(membrane_v[ch]);
        diff = longint'(x) - y;
        y = y + ((diff * longint'(coeff_reg)) >>> 16);
        membrane_v[ch] = y[lifn_pkg::VOLT_W-1:0];
        if (!refr_on_v[ch])
        begin
            if (y >= longint'(thr_reg) + longint'(boost_v[ch]))
            begin
                fired = 1'b1;
                membrane_v[ch] = rest_reg;
                refr_left_v[ch] = refr_len_reg;
                refr_on_v[ch] = 1'b1;
            end
        end
        else
        begin
            if (refr_left_v[ch] == 0)
                expire = 1'b1;
            else
            begin
                refr_left_v[ch] = refr_left_v[ch] - 1'b1;
                expire = (refr_left_v[ch] == 0);
            end
            if (expire)
            begin
                boost_v[ch] = 24'(boost_max_reg);
                refr_on_v[ch] = 1'b0;
            end
        end
        return fired;
    endfunction

    // checks output items, follows register writes, predicts accepted items
    always @(posedge clk)
    begin : bank_monitor
        spike_result_t due;
        bit            fired;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (spikes_due.size() == 0)
                    report_mismatch($sformatf("output item %h with nothing due", m_axis_tdata));
                else
                begin
                    due = spikes_due.pop_front();
                    if (m_axis_tdata[0] !== due.spike)
                        report_mismatch($sformatf("channel %0d spike %b, expected %b",
                                                  due.channel, m_axis_tdata[0], due.spike));
                    if (m_axis_tdata[6:1] !== due.channel)
                        report_mismatch($sformatf("spike_channel %0d, expected %0d",
                                                  m_axis_tdata[6:1], due.channel));
                end
            end
            if (cfg_we)
                apply_register(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
            begin
                fired = integrate_channel(s_axis_tdata[23:0], int'(s_axis_tdata[29:24]));
                due.spike = (pinned_spike == PREDICT) ? fired : pinned_spike[0];
                due.channel = s_axis_tdata[29:24];
                spikes_due.push_back(due);
            end
        end
    end

    // output side, random stalls plus an occasional long hold-off
    initial
    begin : receiver
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_left = LONG_HOLD;
                hold_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // offer one item, with random gaps, until the bank takes it
    task automatic offer_item(input logic [23:0] x, input logic [CH_W-1:0] ch,
                              input int pinned);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, ch, x};
        pinned_spike <= pinned;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // stop offering and wait for every due result
    task automatic settle_bank();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (spikes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [23:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // main stimulus
    initial
    begin : stimulus
        logic [23:0]     x;
        logic [CH_W-1:0] ch;
        logic [23:0]     thr_val;
        logic [23:0]     boost_val;
        logic [23:0]     rest_val;
        logic [23:0]     coeff_val;
        logic [23:0]     decay_val;
        logic [23:0]     refr_val;
        for (int c = 0; c < BANK_SIZE; c++)
        begin
            membrane_v[c] = '0;
            boost_v[c] = '0;
            refr_left_v[c] = '0;
            refr_on_v[c] = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        send_idle_pct = 35;
        recv_idle_pct = 49;
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CONFIG)
            begin
                settle_bank();
                write_register(directed_rows[r].reg_index, directed_rows[r].value);
            end
            else
                offer_item(directed_rows[r].value, directed_rows[r].channel,
                           directed_rows[r].pinned);
        end

        // random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle_bank();
            pinned_spike <= PREDICT;
            case (phase)
                2:
                begin
                    thr_val = 24'h7FFFFF;
                    boost_val = 24'h7FFFFF;
                    rest_val = 24'h7FFFFF;
                    coeff_val = 24'h00FFFF;
                    decay_val = 24'h00FFFF;
                    refr_val = 24'h00FFFF;
                end
                5:
                begin
                    thr_val = 24'h800000;
                    boost_val = 24'h000000;
                    rest_val = 24'h800000;
                    coeff_val = 24'h000000;
                    decay_val = 24'h000000;
                    refr_val = 24'h000000;
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                        thr_val = 24'($urandom);
                    else
                        thr_val = 24'($urandom_range(0, 24'h03FFFF)) - 24'h020000;
                    boost_val = 24'($urandom_range(0, 24'h7FFFFF) >> $urandom_range(0, 8));
                    rest_val = 24'($urandom);
                    coeff_val = 24'($urandom_range(16'h2000, 16'hFFFF));
                    decay_val = 24'($urandom_range(0, 16'hFFFF));
                    refr_val = 24'($urandom_range(0, 6));
                end
            endcase
            write_register(lifn_pkg::CFG_FIRE_THRESHOLD, thr_val);
            write_register(lifn_pkg::CFG_MAX_THRESHOLD_BOOST, boost_val);
            write_register(lifn_pkg::CFG_REST_LEVEL, rest_val);
            write_register(lifn_pkg::CFG_FILTER_COEFF, coeff_val);
            write_register(lifn_pkg::CFG_BOOST_DECAY, decay_val);
            write_register(lifn_pkg::CFG_REFRACTORY_SAMPLES, refr_val);

            // idling pattern per phase
            if (phase < 2)
            begin
                send_idle_pct = 35;
                recv_idle_pct = 49;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 35;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // fill the bank against a stalled receiver
            if (phase == PHASES - 1)
                hold_requests++;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mostly samples near the threshold on a few busy channels
                if ($urandom_range(0, 3) == 0)
                    x = 24'($urandom);
                else
                    x = thr_val + 24'($urandom_range(0, 24'h0FFFFF)) - 24'h080000;
                if ($urandom_range(0, 9) < 6)
                    ch = CH_W'($urandom_range(0, 3));
                else
                    ch = CH_W'($urandom_range(0, BANK_SIZE - 1));
                offer_item(x, ch, PREDICT);
            end
        end

        settle_bank();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
